// ----- src/nnsa_pkg.sv -----
// nnsa_pkg: types and constants shared by the nearest-neighbor scale address generator.
// Holds the register file layout, register index codes, job flags and back-end states.
// No dependencies.
`default_nettype none
package nnsa_pkg;

	localparam int ORIGIN_W    = 24;
	localparam int DIM_REG_W   = 14;
	localparam int INDEX_OUT_W = 24;
	localparam int REG_IDX_W   = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SRC_ORIGIN = 3'd0,
		REG_DST_ORIGIN = 3'd1,
		REG_SRC_PITCH  = 3'd2,
		REG_DST_PITCH  = 3'd3,
		REG_SRC_WIDTH  = 3'd4,
		REG_SRC_HEIGHT = 3'd5,
		REG_DST_WIDTH  = 3'd6,
		REG_DST_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [ORIGIN_W-1:0]  src_origin;
		logic [ORIGIN_W-1:0]  dst_origin;
		logic [DIM_REG_W-1:0] src_pitch;
		logic [DIM_REG_W-1:0] dst_pitch;
		logic [DIM_REG_W-1:0] src_width;
		logic [DIM_REG_W-1:0] src_height;
		logic [DIM_REG_W-1:0] dst_width;
		logic [DIM_REG_W-1:0] dst_height;
	} cfg_t;

	typedef struct packed {
		logic pixel;
		logic row_end;
		logic last;
	} job_flags_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_ADD  = 5'b10000
	} back_state_t;

endpackage
`default_nettype wire

// ----- src/nnsa_front.sv -----
// nnsa_front: configuration registers and the destination walk (row/col counters).
// Classifies each item and pushes a job toward the back end.
// Depends on nnsa_pkg.
`default_nettype none
module nnsa_front #(
	parameter int MAX_DIM = 8192,
	parameter int CNT_W   = 13,
	parameter int DIM_W   = 14
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [nnsa_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire logic [nnsa_pkg::ORIGIN_W-1:0]          cfg_data,
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic                                   start_req,
	input  wire logic                                   q_full,
	output      logic                                   push,
	output      nnsa_pkg::job_flags_t                   job_flags,
	output      logic [CNT_W-1:0]                       job_row,
	output      logic [CNT_W-1:0]                       job_col,
	output      logic [DIM_W-1:0]                       job_dw,
	output      logic [DIM_W-1:0]                       job_dh,
	output      nnsa_pkg::cfg_t                         cfg
);

	nnsa_pkg::cfg_t cfg_q;
	logic [CNT_W-1:0] row_q, col_q;
	logic             active_q;

	logic [CNT_W-1:0] row_eff, col_eff, row_nxt, col_nxt;
	logic             act_eff, active_nxt;
	logic [31:0]      dw_ext, dh_ext;
	logic             pix, rend, lst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (nnsa_pkg::reg_idx_t'(cfg_index))
				nnsa_pkg::REG_SRC_ORIGIN: cfg_q.src_origin <= cfg_data;
				nnsa_pkg::REG_DST_ORIGIN: cfg_q.dst_origin <= cfg_data;
				nnsa_pkg::REG_SRC_PITCH:  cfg_q.src_pitch  <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				nnsa_pkg::REG_DST_PITCH:  cfg_q.dst_pitch  <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				nnsa_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				nnsa_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				nnsa_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				nnsa_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[nnsa_pkg::DIM_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// clamp destination size to MAX_DIM
	assign dw_ext = (32'(cfg_q.dst_width) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(cfg_q.dst_width);
	assign dh_ext = (32'(cfg_q.dst_height) > 32'(MAX_DIM)) ? 32'(MAX_DIM) : 32'(cfg_q.dst_height);

	assign row_eff = start_req ? '0 : row_q;
	assign col_eff = start_req ? '0 : col_q;
	assign act_eff = start_req | active_q;

	assign pix  = act_eff && (dw_ext != 32'd0) && (dh_ext != 32'd0);
	assign rend = (32'(col_eff) + 32'd1) >= dw_ext;
	assign lst  = rend && ((32'(row_eff) + 32'd1) >= dh_ext);

	always_comb begin
		row_nxt    = row_eff;
		col_nxt    = col_eff;
		active_nxt = 1'b0;
		if (pix) begin
			if (lst) begin
				row_nxt = '0;
				col_nxt = '0;
			end else if (rend) begin
				active_nxt = 1'b1;
				col_nxt    = '0;
				row_nxt    = row_eff + CNT_W'(1);
			end else begin
				active_nxt = 1'b1;
				col_nxt    = col_eff + CNT_W'(1);
			end
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			active_q <= 1'b0;
		end else if (push) begin
			row_q    <= row_nxt;
			col_q    <= col_nxt;
			active_q <= active_nxt;
		end
	end

	assign job_flags.pixel   = pix;
	assign job_flags.row_end = pix && rend;
	assign job_flags.last    = pix && lst;
	assign job_row           = row_eff;
	assign job_col           = col_eff;
	assign job_dw            = dw_ext[DIM_W-1:0];
	assign job_dh            = dh_ext[DIM_W-1:0];

endmodule
`default_nettype wire

// ----- src/nnsa_queue.sv -----
// nnsa_queue: two-entry job queue between front and back end.
// Generic payload width; no package dependency.
`default_nettype none
module nnsa_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output      logic         full,
	input  wire logic         pop,
	output      logic [W-1:0] rdata,
	output      logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/nnsa_back.sv -----
// nnsa_back: computes source/destination indices for one job at a time.
// Bit-serial dividers for row and column scaling, then multiply, add, output register.
// Depends on nnsa_pkg.
`default_nettype none
module nnsa_back #(
	parameter int CNT_W      = 13,
	parameter int DIM_W      = 14,
	parameter int INDEX_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire nnsa_pkg::cfg_t                         cfg,
	input  wire logic                                   q_empty,
	output      logic                                   pop,
	input  wire nnsa_pkg::job_flags_t                   job_flags,
	input  wire logic [CNT_W-1:0]                       job_row,
	input  wire logic [CNT_W-1:0]                       job_col,
	input  wire logic [DIM_W-1:0]                       job_dw,
	input  wire logic [DIM_W-1:0]                       job_dh,
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      logic                                   valid_res,
	output      logic [nnsa_pkg::INDEX_OUT_W-1:0]       src_index,
	output      logic [nnsa_pkg::INDEX_OUT_W-1:0]       dst_index,
	output      logic                                   row_end,
	output      logic                                   last,
	output      logic                                   range_error
);

	localparam int NUM_W  = CNT_W + nnsa_pkg::DIM_REG_W;
	localparam int SRC_W  = NUM_W + nnsa_pkg::DIM_REG_W;
	localparam int SUM_W  = SRC_W + 2;
	localparam int STEP_W = $clog2(NUM_W);
	localparam int OUT_W  = nnsa_pkg::INDEX_OUT_W;
	localparam logic [OUT_W-1:0] OUT_MASK = (INDEX_BITS >= OUT_W) ? {OUT_W{1'b1}} :
		OUT_W'((33'd1 << INDEX_BITS) - 33'd1);

	nnsa_pkg::back_state_t state_q;
	nnsa_pkg::job_flags_t  jflags_q;
	logic [CNT_W-1:0]      jrow_q, jcol_q;
	logic [DIM_W-1:0]      jdw_q, jdh_q;
	logic [NUM_W-1:0]      nq_row_q, nq_col_q, dprod_q;
	logic [DIM_W-1:0]      rem_row_q, rem_col_q;
	logic [STEP_W-1:0]     step_q;
	logic [SRC_W-1:0]      srow_q;

	logic                  out_valid_q, valid_res_q, row_end_q, last_q, range_error_q;
	logic [OUT_W-1:0]      src_index_q, dst_index_q;

	logic [DIM_W:0]        trial_row, trial_col, sub_row, sub_col;
	logic                  ge_row, ge_col;
	logic [SUM_W-1:0]      s_sum, d_sum;
	logic                  err, out_free;

	assign trial_row = {rem_row_q, nq_row_q[NUM_W-1]};
	assign trial_col = {rem_col_q, nq_col_q[NUM_W-1]};
	assign ge_row    = trial_row >= {1'b0, jdh_q};
	assign ge_col    = trial_col >= {1'b0, jdw_q};
	assign sub_row   = ge_row ? (trial_row - {1'b0, jdh_q}) : trial_row;
	assign sub_col   = ge_col ? (trial_col - {1'b0, jdw_q}) : trial_col;

	assign s_sum = SUM_W'(cfg.src_origin) + SUM_W'(srow_q) + SUM_W'(nq_col_q);
	assign d_sum = SUM_W'(cfg.dst_origin) + SUM_W'(dprod_q) + SUM_W'(jcol_q);
	assign err   = (|(s_sum >> INDEX_BITS)) || (|(d_sum >> INDEX_BITS));

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == nnsa_pkg::ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnsa_pkg::ST_IDLE;
		end else begin
			case (state_q)
				nnsa_pkg::ST_IDLE: begin
					if (!q_empty) begin
						state_q <= nnsa_pkg::ST_LOAD;
					end
				end
				nnsa_pkg::ST_LOAD: state_q <= nnsa_pkg::ST_DIV;
				nnsa_pkg::ST_DIV: begin
					if (step_q == STEP_W'(NUM_W - 1)) begin
						state_q <= nnsa_pkg::ST_MUL;
					end
				end
				nnsa_pkg::ST_MUL: state_q <= nnsa_pkg::ST_ADD;
				nnsa_pkg::ST_ADD: begin
					if (out_free) begin
						state_q <= nnsa_pkg::ST_IDLE;
					end
				end
				default: state_q <= nnsa_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			nnsa_pkg::ST_IDLE: begin
				jflags_q <= job_flags;
				jrow_q   <= job_row;
				jcol_q   <= job_col;
				jdw_q    <= job_dw;
				jdh_q    <= job_dh;
			end
			nnsa_pkg::ST_LOAD: begin
				nq_row_q  <= NUM_W'(jrow_q) * NUM_W'(cfg.src_height);
				nq_col_q  <= NUM_W'(jcol_q) * NUM_W'(cfg.src_width);
				dprod_q   <= NUM_W'(jrow_q) * NUM_W'(cfg.dst_pitch);
				rem_row_q <= '0;
				rem_col_q <= '0;
				step_q    <= '0;
			end
			nnsa_pkg::ST_DIV: begin
				rem_row_q <= sub_row[DIM_W-1:0];
				rem_col_q <= sub_col[DIM_W-1:0];
				nq_row_q  <= {nq_row_q[NUM_W-2:0], ge_row};
				nq_col_q  <= {nq_col_q[NUM_W-2:0], ge_col};
				step_q    <= step_q + STEP_W'(1);
			end
			nnsa_pkg::ST_MUL: begin
				srow_q <= SRC_W'(nq_row_q) * SRC_W'(cfg.src_pitch);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == nnsa_pkg::ST_ADD) && out_free) begin
			valid_res_q   <= jflags_q.pixel;
			row_end_q     <= jflags_q.row_end;
			last_q        <= jflags_q.last;
			range_error_q <= jflags_q.pixel && err;
			src_index_q   <= jflags_q.pixel ? (s_sum[OUT_W-1:0] & OUT_MASK) : '0;
			dst_index_q   <= jflags_q.pixel ? (d_sum[OUT_W-1:0] & OUT_MASK) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == nnsa_pkg::ST_ADD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign valid_res   = valid_res_q;
	assign src_index   = src_index_q;
	assign dst_index   = dst_index_q;
	assign row_end     = row_end_q;
	assign last        = last_q;
	assign range_error = range_error_q;

endmodule
`default_nettype wire

// ----- src/nearest_neighbor_scale_address_gen.sv -----
// Top level of the nearest-neighbor scale address generator.
// Instantiates nnsa_front, nnsa_queue and nnsa_back; depends on nnsa_pkg.
// Each accepted item yields one result: the next destination pixel of a dst_width by
// dst_height walk in row-major order, with its scaled source word index and its
// destination word index; start_req=1 restarts at pixel (0,0), valid_res=0 means no
// pixel was left or the rectangle is empty. The front end accepts items and steps the
// walk at once, holding up to two jobs in a queue, so in_stall rises only when the
// queue is full. The back end takes one job at a time, no new job before the last is
// done; its bit-serial dividers scale the row and column, one quotient bit per cycle.
// Registers are written through cfg_wr_en, cfg_index and cfg_data; the user must write
// them only while no item is in flight, and the block itself does not enforce this.
`default_nettype none
module nearest_neighbor_scale_address_gen #(
	parameter int MAX_DIM    = 8192,
	parameter int INDEX_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [nnsa_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire logic [nnsa_pkg::ORIGIN_W-1:0]          cfg_data,
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic                                   start_req,
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      logic                                   valid_res,
	output      logic [nnsa_pkg::INDEX_OUT_W-1:0]       src_index,
	output      logic [nnsa_pkg::INDEX_OUT_W-1:0]       dst_index,
	output      logic                                   row_end,
	output      logic                                   last,
	output      logic                                   range_error
);

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int FLG_W = $bits(nnsa_pkg::job_flags_t);
	localparam int JOB_W = FLG_W + 2 * CNT_W + 2 * DIM_W;

	nnsa_pkg::cfg_t       cfg;
	nnsa_pkg::job_flags_t f_flags, b_flags;
	logic [CNT_W-1:0]     f_row, f_col, b_row, b_col;
	logic [DIM_W-1:0]     f_dw, f_dh, b_dw, b_dh;
	logic                 push, pop, q_full, q_empty;
	logic [JOB_W-1:0]     q_wdata, q_rdata;

	nnsa_front #(
		.MAX_DIM (MAX_DIM),
		.CNT_W   (CNT_W),
		.DIM_W   (DIM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.start_req (start_req),
		.q_full    (q_full),
		.push      (push),
		.job_flags (f_flags),
		.job_row   (f_row),
		.job_col   (f_col),
		.job_dw    (f_dw),
		.job_dh    (f_dh),
		.cfg       (cfg)
	);

	assign q_wdata = {f_flags, f_row, f_col, f_dw, f_dh};
	assign {b_flags, b_row, b_col, b_dw, b_dh} = q_rdata;

	nnsa_queue #(
		.W (JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	nnsa_back #(
		.CNT_W      (CNT_W),
		.DIM_W      (DIM_W),
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_empty     (q_empty),
		.pop         (pop),
		.job_flags   (b_flags),
		.job_row     (b_row),
		.job_col     (b_col),
		.job_dw      (b_dw),
		.job_dh      (b_dh),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.valid_res   (valid_res),
		.src_index   (src_index),
		.dst_index   (dst_index),
		.row_end     (row_end),
		.last        (last),
		.range_error (range_error)
	);

endmodule
`default_nettype wire

// ----- src/nnsa_checker.sv -----
// nnsa_checker: port-level assertions for nearest_neighbor_scale_address_gen.
// Bound to the top level below; depends on nnsa_pkg.
`default_nettype none
module nnsa_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic                               valid_res,
	input wire logic [nnsa_pkg::INDEX_OUT_W-1:0]   src_index,
	input wire logic [nnsa_pkg::INDEX_OUT_W-1:0]   dst_index,
	input wire logic                               row_end,
	input wire logic                               last,
	input wire logic                               range_error
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(src_index) && $stable(dst_index)
			&& $stable(valid_res) && $stable(last))
		else $error("result item changed while stalled");

	a_last_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> row_end && valid_res)
		else $error("last without row_end or pixel");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> src_index == '0 && dst_index == '0 && !row_end
			&& !last && !range_error)
		else $error("empty item carries nonzero fields");

endmodule

bind nearest_neighbor_scale_address_gen nnsa_checker u_nnsa_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbor_scale_address_gen: a directed table, then random
// rectangles and register changes mid-walk, every result checked against a walk model kept here.
// Depends on nnsa_pkg and the nearest_neighbor_scale_address_gen RTL.
module testbench;

	localparam int          MAX_DIM     = 8192;
	localparam int          INDEX_BITS  = 24;
	localparam logic [63:0] INDEX_LIM   = (64'd1 << INDEX_BITS) - 64'd1;
	localparam int          RAND_ITEMS  = 800;
	localparam int          QUIET_LIMIT = 2000;
	localparam int          TAIL_CYCLES = 40;

	typedef struct packed {
		logic                             valid;
		logic [nnsa_pkg::INDEX_OUT_W-1:0] src;
		logic [nnsa_pkg::INDEX_OUT_W-1:0] dst;
		logic                             row_end;
		logic                             last;
		logic                             err;
	} pixel_t;

	typedef struct packed {
		logic   typed;
		pixel_t want;
	} pending_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		nnsa_pkg::reg_idx_t            idx;
		logic [nnsa_pkg::ORIGIN_W-1:0] data;
		logic                          start;
		logic                          typed;
		pixel_t                        want;
	} row_t;

	localparam pixel_t NO_PIX = '0;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [nnsa_pkg::REG_IDX_W-1:0]   cfg_index = '0;
	logic [nnsa_pkg::ORIGIN_W-1:0]    cfg_data  = '0;
	logic                             in_valid  = 1'b0;
	logic                             start_req = 1'b0;
	logic                             out_stall = 1'b0;
	logic                             in_stall;
	logic                             out_valid;
	logic                             valid_res;
	logic [nnsa_pkg::INDEX_OUT_W-1:0] src_index;
	logic [nnsa_pkg::INDEX_OUT_W-1:0] dst_index;
	logic                             row_end;
	logic                             last;
	logic                             range_error;

	nearest_neighbor_scale_address_gen #(
		.MAX_DIM(MAX_DIM),
		.INDEX_BITS(INDEX_BITS)
	) dut (.*);

	// walk model
	nnsa_pkg::cfg_t regs     = '0;
	logic [12:0]    walk_row = '0;
	logic [12:0]    walk_col = '0;
	logic           walk_on  = 1'b0;

	pixel_t   pixel_q   [$];
	pending_t pending_q [$];
	row_t     dir_tab   [$];

	int     errors    = 0;
	int     out_count = 0;
	int     in_pct    = 0;
	int     out_pct   = 0;
	int     quiet     = 0;
	longint drv_dw    = 0;
	longint drv_dh    = 0;
	longint drv_steps = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic pixel_t scale_step(input logic restart);
		pixel_t      p;
		logic [63:0] dw, dh, s, d;
		p  = NO_PIX;
		dw = (regs.dst_width > MAX_DIM) ? 64'(MAX_DIM) : 64'(regs.dst_width);
		dh = (regs.dst_height > MAX_DIM) ? 64'(MAX_DIM) : 64'(regs.dst_height);
		if (restart) begin
			walk_row = '0;
			walk_col = '0;
			walk_on  = 1'b1;
		end
		if (!walk_on || dw == 0 || dh == 0) begin
			walk_on = 1'b0;
			return p;
		end
		s = 64'(regs.src_origin)
			+ (64'(walk_row) * 64'(regs.src_height) / dh) * 64'(regs.src_pitch)
			+ 64'(walk_col) * 64'(regs.src_width) / dw;
		d = 64'(regs.dst_origin) + 64'(walk_row) * 64'(regs.dst_pitch) + 64'(walk_col);
		p.valid   = 1'b1;
		p.src     = nnsa_pkg::INDEX_OUT_W'(s & INDEX_LIM);
		p.dst     = nnsa_pkg::INDEX_OUT_W'(d & INDEX_LIM);
		p.err     = (s > INDEX_LIM) || (d > INDEX_LIM);
		p.row_end = (64'(walk_col) + 64'd1 >= dw);
		p.last    = p.row_end && (64'(walk_row) + 64'd1 >= dh);
		if (p.last) begin
			walk_on  = 1'b0;
			walk_row = '0;
			walk_col = '0;
		end else if (p.row_end) begin
			walk_col = '0;
			walk_row = walk_row + 13'd1;
		end else begin
			walk_col = walk_col + 13'd1;
		end
		return p;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin : monitor
		pixel_t   got;
		pixel_t   want;
		pending_t note;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (nnsa_pkg::reg_idx_t'(cfg_index))
					nnsa_pkg::REG_SRC_ORIGIN: regs.src_origin = cfg_data;
					nnsa_pkg::REG_DST_ORIGIN: regs.dst_origin = cfg_data;
					nnsa_pkg::REG_SRC_PITCH:  regs.src_pitch  = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					nnsa_pkg::REG_DST_PITCH:  regs.dst_pitch  = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					nnsa_pkg::REG_SRC_WIDTH:  regs.src_width  = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					nnsa_pkg::REG_SRC_HEIGHT: regs.src_height = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					nnsa_pkg::REG_DST_WIDTH:  regs.dst_width  = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					nnsa_pkg::REG_DST_HEIGHT: regs.dst_height = cfg_data[nnsa_pkg::DIM_REG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				want = scale_step(start_req);
				if (pending_q.size() != 0) begin
					note = pending_q.pop_front();
					if (note.typed)
						want = note.want;
				end
				pixel_q.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = '{valid_res, src_index, dst_index, row_end, last, range_error};
				if (pixel_q.size() == 0) begin
					note_mismatch($sformatf("result %0d arrived with none pending", out_count));
				end else begin
					want = pixel_q.pop_front();
					if (got.valid !== want.valid)
						note_mismatch($sformatf("result %0d: valid_res %b, expected %b",
							out_count, got.valid, want.valid));
					if (got.src !== want.src)
						note_mismatch($sformatf("result %0d: src_index %h, expected %h",
							out_count, got.src, want.src));
					if (got.dst !== want.dst)
						note_mismatch($sformatf("result %0d: dst_index %h, expected %h",
							out_count, got.dst, want.dst));
					if (got.row_end !== want.row_end)
						note_mismatch($sformatf("result %0d: row_end %b, expected %b",
							out_count, got.row_end, want.row_end));
					if (got.last !== want.last)
						note_mismatch($sformatf("result %0d: last %b, expected %b",
							out_count, got.last, want.last));
					if (got.err !== want.err)
						note_mismatch($sformatf("result %0d: range_error %b, expected %b",
							out_count, got.err, want.err));
				end
				out_count++;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= (out_pct > 0) && ($urandom_range(99) < out_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_item(input logic st, input logic typed, input pixel_t want);
		pending_t note;
		while (in_pct > 0 && $urandom_range(99) < in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		note.typed = typed;
		note.want  = want;
		pending_q.push_back(note);
		in_valid  <= 1'b1;
		start_req <= st;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// sender holds off until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0 || pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input nnsa_pkg::reg_idx_t idx,
			input logic [nnsa_pkg::ORIGIN_W-1:0] data);
		logic [nnsa_pkg::DIM_REG_W-1:0] dim;
		dim = data[nnsa_pkg::DIM_REG_W-1:0];
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx == nnsa_pkg::REG_DST_WIDTH)
			drv_dw = (dim > MAX_DIM) ? MAX_DIM : dim;
		if (idx == nnsa_pkg::REG_DST_HEIGHT)
			drv_dh = (dim > MAX_DIM) ? MAX_DIM : dim;
	endtask

	function automatic logic [nnsa_pkg::ORIGIN_W-1:0] pick_origin();
		if ($urandom_range(3) == 0)
			return 24'hFFFFFF - 24'($urandom_range(300));
		return 24'($urandom());
	endfunction

	function automatic logic [nnsa_pkg::ORIGIN_W-1:0] pick_dim(input int least, input int most,
			input int odd_pct);
		if ($urandom_range(99) < odd_pct) begin
			case ($urandom_range(3))
				0: return '0;
				1: return 24'(MAX_DIM);
				2: return 24'(16383);
				default: return 24'($urandom_range(16383));
			endcase
		end
		return 24'($urandom_range(most, least));
	endfunction

	function automatic row_t cfg_row(input nnsa_pkg::reg_idx_t idx,
			input logic [nnsa_pkg::ORIGIN_W-1:0] data);
		return '{ROW_CFG, idx, data, 1'b0, 1'b0, NO_PIX};
	endfunction

	function automatic row_t item_row(input logic st);
		return '{ROW_ITEM, nnsa_pkg::REG_SRC_ORIGIN, '0, st, 1'b0, NO_PIX};
	endfunction

	function automatic row_t typed_row(input logic st, input pixel_t want);
		return '{ROW_ITEM, nnsa_pkg::REG_SRC_ORIGIN, '0, st, 1'b1, want};
	endfunction

	function automatic pixel_t pix(input logic [23:0] s, input logic [23:0] d,
			input logic re, input logic la, input logic er);
		return '{1'b1, s, d, re, la, er};
	endfunction

	initial begin
		int                 phase;
		int                 sent;
		int                 n;
		logic               st;
		logic               fresh;
		logic               cfg_open;
		nnsa_pkg::reg_idx_t idx;

		dir_tab = '{
			typed_row(1'b0, NO_PIX),
			typed_row(1'b1, NO_PIX),
			cfg_row(nnsa_pkg::REG_SRC_ORIGIN, 24'd100),
			cfg_row(nnsa_pkg::REG_DST_ORIGIN, 24'd200),
			cfg_row(nnsa_pkg::REG_SRC_PITCH, 24'd10),
			cfg_row(nnsa_pkg::REG_DST_PITCH, 24'd20),
			cfg_row(nnsa_pkg::REG_SRC_WIDTH, 24'd4),
			cfg_row(nnsa_pkg::REG_SRC_HEIGHT, 24'd4),
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd2),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd2),
			typed_row(1'b1, pix(24'd100, 24'd200, 1'b0, 1'b0, 1'b0)),
			typed_row(1'b0, pix(24'd102, 24'd201, 1'b1, 1'b0, 1'b0)),
			typed_row(1'b0, pix(24'd120, 24'd220, 1'b0, 1'b0, 1'b0)),
			typed_row(1'b0, pix(24'd122, 24'd221, 1'b1, 1'b1, 1'b0)),
			typed_row(1'b0, NO_PIX),
			// shrink under a running walk: column, then row beyond the new size
			item_row(1'b1),
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd1),
			item_row(1'b0),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd1),
			item_row(1'b0),
			item_row(1'b0),
			// destination emptied mid-walk
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd3),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd3),
			item_row(1'b1),
			item_row(1'b0),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd0),
			typed_row(1'b0, NO_PIX),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd3),
			typed_row(1'b0, NO_PIX),
			// index overflow
			cfg_row(nnsa_pkg::REG_SRC_ORIGIN, 24'hFFFFFF),
			cfg_row(nnsa_pkg::REG_DST_ORIGIN, 24'hFFFFFF),
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd2),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd1),
			typed_row(1'b1, pix(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0)),
			typed_row(1'b0, pix(24'h000001, 24'h000000, 1'b1, 1'b1, 1'b1)),
			// widest registers, dimensions above the walk limit
			cfg_row(nnsa_pkg::REG_SRC_ORIGIN, 24'd0),
			cfg_row(nnsa_pkg::REG_DST_ORIGIN, 24'd0),
			cfg_row(nnsa_pkg::REG_SRC_PITCH, 24'd16383),
			cfg_row(nnsa_pkg::REG_DST_PITCH, 24'd16383),
			cfg_row(nnsa_pkg::REG_SRC_WIDTH, 24'd16383),
			cfg_row(nnsa_pkg::REG_SRC_HEIGHT, 24'd16383),
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd16383),
			cfg_row(nnsa_pkg::REG_DST_HEIGHT, 24'd16383),
			typed_row(1'b1, pix(24'd0, 24'd0, 1'b0, 1'b0, 1'b0)),
			item_row(1'b0),
			item_row(1'b0),
			cfg_row(nnsa_pkg::REG_DST_WIDTH, 24'd1),
			item_row(1'b0),
			item_row(1'b0)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		in_pct   = 29;
		out_pct  = 29;
		cfg_open = 1'b0;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				if (!cfg_open)
					settle();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
				cfg_open = 1'b1;
			end else begin
				cfg_wr_en <= 1'b0;
				cfg_open = 1'b0;
				send_item(dir_tab[i].start, dir_tab[i].typed, dir_tab[i].want);
			end
		end

		phase = 0;
		sent  = 0;
		while (sent < RAND_ITEMS) begin
			settle();
			case (phase % 4)
				0: begin
					in_pct  = 0;
					out_pct = 0;
				end
				1: begin
					in_pct  = 62;
					out_pct = 0;
				end
				2: begin
					in_pct  = 0;
					out_pct = 62;
				end
				default: begin
					in_pct  = 29;
					out_pct = 29;
				end
			endcase
			if ($urandom_range(9) < 3) begin
				// new register values under the walk in progress
				fresh = 1'b0;
				repeat ($urandom_range(2, 1)) begin
					idx = nnsa_pkg::reg_idx_t'($urandom_range(7));
					if (idx == nnsa_pkg::REG_SRC_ORIGIN || idx == nnsa_pkg::REG_DST_ORIGIN)
						write_reg(idx, pick_origin());
					else if (idx == nnsa_pkg::REG_DST_WIDTH || idx == nnsa_pkg::REG_DST_HEIGHT)
						write_reg(idx, pick_dim(0, 6, 12));
					else
						write_reg(idx, pick_dim(0, 40, 50));
				end
			end else begin
				fresh = 1'b1;
				write_reg(nnsa_pkg::REG_SRC_ORIGIN, pick_origin());
				write_reg(nnsa_pkg::REG_DST_ORIGIN, pick_origin());
				write_reg(nnsa_pkg::REG_SRC_PITCH, pick_dim(0, 40, 50));
				write_reg(nnsa_pkg::REG_DST_PITCH, pick_dim(0, 40, 50));
				write_reg(nnsa_pkg::REG_SRC_WIDTH, pick_dim(0, 40, 50));
				write_reg(nnsa_pkg::REG_SRC_HEIGHT, pick_dim(0, 40, 50));
				write_reg(nnsa_pkg::REG_DST_WIDTH, pick_dim(1, 6, 12));
				write_reg(nnsa_pkg::REG_DST_HEIGHT, pick_dim(1, 6, 12));
			end
			cfg_wr_en <= 1'b0;
			n = $urandom_range(40, 8);
			repeat (n) begin
				if (fresh)
					st = 1'b1;
				else if (drv_steps >= drv_dw * drv_dh)
					st = ($urandom_range(3) != 0);
				else
					st = ($urandom_range(19) == 0);
				fresh = 1'b0;
				send_item(st, 1'b0, NO_PIX);
				drv_steps = st ? 1 : drv_steps + 1;
				sent++;
			end
			phase++;
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
